// File: rtl/crcrx_pkg.sv
// Shared types, codes and the CRC16-CCITT byte update for the reply frame receiver.
// No dependencies; every other file of the block but the interface file imports this package.
package crcrx_pkg;

  localparam int PAY_DEPTH = 11;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [4:0] HEAD_BYTES = 5'd5;  // start, command, length, two CRC bytes

  // item kinds
  localparam logic [1:0] REQ_ARM  = 2'd0;
  localparam logic [1:0] REQ_BYTE = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_START = 3'd1;
  localparam logic [2:0] ST_TOO_LONG  = 3'd2;
  localparam logic [2:0] ST_CRC_BAD   = 3'd3;
  localparam logic [2:0] ST_CMD_BAD   = 3'd4;
  localparam logic [2:0] ST_TIMEOUT   = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_REPLY_SOF     = 2'd0;
  localparam logic [1:0] CFG_CRC_INIT      = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

  // datapath operations
  localparam logic [3:0] DP_NOP    = 4'd0;
  localparam logic [3:0] DP_LOAD   = 4'd1;
  localparam logic [3:0] DP_ARM    = 4'd2;
  localparam logic [3:0] DP_TICK   = 4'd3;
  localparam logic [3:0] DP_BYTE   = 4'd4;
  localparam logic [3:0] DP_REJECT = 4'd5;
  localparam logic [3:0] DP_EMPTY  = 4'd6;
  localparam logic [3:0] DP_FIRST  = 4'd7;
  localparam logic [3:0] DP_NEXT   = 4'd8;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] code;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       armed;
    logic       time_zero;
    logic       checking;
    logic       bad_sof;
    logic       too_long;
    logic       at_end;
    logic       crc_bad;
    logic       cmd_bad;
    logic       len_zero;
    logic       out_last;
  } dp_stat_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      x = x[15] ? ((x << 1) ^ CRC_POLY) : (x << 1);
    end
    return x;
  endfunction

endpackage

// File: rtl/crcrx_if.sv
// Valid/ready channel interfaces for the request items and the result items.
// Depends on nothing; used by the top level of the receiver.
interface crcrx_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] expected_cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output expected_cmd, output rx_byte,
                  input ready);
  modport sink   (input valid, input req_type, input expected_cmd, input rx_byte,
                  output ready);
endinterface

interface crcrx_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  data_byte;
  logic        data_valid;
  logic [3:0]  byte_index;
  logic [3:0]  payload_len;
  logic        last;
  logic [31:0] desync_count;

  modport source (output valid, output status, output data_byte, output data_valid,
                  output byte_index, output payload_len, output last, output desync_count,
                  input ready);
  modport sink   (input valid, input status, input data_byte, input data_valid,
                  input byte_index, input payload_len, input last, input desync_count,
                  output ready);
endinterface

// File: rtl/crcrx_ctrl.sv
// Controller of the reply frame receiver: item sequencing, frame checks, result burst.
// Depends on crcrx_pkg; drives crcrx_dp through dp_cmd_t and reads dp_stat_t.
module crcrx_ctrl
  import crcrx_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = DP_NOP;
    cmd.code  = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = DP_LOAD;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        unique case (stat.req_type)
          REQ_ARM: begin
            cmd.op    = DP_ARM;
            state_nxt = S_EVAL;
          end
          REQ_BYTE: begin
            if (stat.armed) begin
              cmd.op    = DP_BYTE;
              state_nxt = S_EVAL;
            end
          end
          REQ_TICK: begin
            if (stat.armed) begin
              cmd.op    = DP_TICK;
              state_nxt = S_EVAL;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_EVAL: begin
        state_nxt = S_OUT;
        if (stat.req_type != REQ_BYTE) begin
          // arm or tick: only the timeout can end the frame here
          if (stat.time_zero) begin
            cmd.op   = DP_REJECT;
            cmd.code = ST_TIMEOUT;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          priority if (!stat.checking) begin
            state_nxt = S_IDLE;
          end else if (stat.bad_sof) begin
            cmd.op   = DP_REJECT;
            cmd.code = ST_BAD_START;
          end else if (stat.too_long) begin
            cmd.op   = DP_REJECT;
            cmd.code = ST_TOO_LONG;
          end else if (!stat.at_end) begin
            state_nxt = S_IDLE;
          end else if (stat.crc_bad) begin
            cmd.op   = DP_REJECT;
            cmd.code = ST_CRC_BAD;
          end else if (stat.cmd_bad) begin
            cmd.op   = DP_REJECT;
            cmd.code = ST_CMD_BAD;
          end else if (stat.len_zero) begin
            cmd.op = DP_EMPTY;
          end else begin
            cmd.op = DP_FIRST;
          end
        end
      end
      S_OUT: begin
        if (out_ready) begin
          if (stat.out_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.op = DP_NEXT;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // one item in flight: never take a new item while a result is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  // the final result of a burst hands control straight back to the input side
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && stat.out_last) |=> in_ready)
    else $error("not idle after the final result");

endmodule

// File: rtl/crcrx_dp.sv
// Datapath of the reply frame receiver: config registers, frame state, CRC, payload
// buffer and the result register. Depends on crcrx_pkg; commanded by crcrx_ctrl.
module crcrx_dp
  import crcrx_pkg::*;
#(
  parameter int PAY_LIMIT = 11
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_expected_cmd,
  input  logic [7:0]  in_rx_byte,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  input  logic        out_valid,
  output logic [2:0]  out_status,
  output logic [7:0]  out_data_byte,
  output logic        out_data_valid,
  output logic [3:0]  out_byte_index,
  output logic [3:0]  out_payload_len,
  output logic        out_last,
  output logic [31:0] out_desync_count
);

  logic [7:0]  reply_sof_r;
  logic [15:0] crc_init_r;
  logic [23:0] timeout_ticks_r;

  logic [1:0]  type_r;
  logic [7:0]  item_cmd_r;
  logic [7:0]  item_byte_r;

  logic        armed_r;
  logic [4:0]  byte_count_r;
  logic [7:0]  want_cmd_r;
  logic [7:0]  frame_len_r;
  logic [15:0] crc_acc_r;
  logic [15:0] crc_rx_r;
  logic [7:0]  head_sof_r;
  logic [7:0]  head_cmd_r;
  logic [23:0] time_left_r;
  logic [31:0] desync_r;
  logic [7:0]  payload_r [PAY_DEPTH];

  logic [2:0]  status_r;
  logic [7:0]  data_byte_r;
  logic        data_valid_r;
  logic [3:0]  byte_index_r;
  logic [3:0]  payload_len_r;
  logic        last_r;
  logic [31:0] desync_out_r;

  logic [4:0]  pay_pos;
  logic [3:0]  next_index;
  logic [8:0]  frame_total;
  logic [15:0] crc_next;

  assign pay_pos     = byte_count_r - 5'd3;
  assign next_index  = byte_index_r + 4'd1;
  assign frame_total = {1'b0, frame_len_r} + 9'(HEAD_BYTES);
  assign crc_next    = crc_feed(crc_acc_r, item_byte_r);

  always_comb begin
    stat.req_type  = type_r;
    stat.armed     = armed_r;
    stat.time_zero = (time_left_r == 24'd0);
    stat.checking  = (byte_count_r >= HEAD_BYTES);
    stat.bad_sof   = (head_sof_r != reply_sof_r);
    stat.too_long  = (frame_len_r > 8'(PAY_LIMIT));
    stat.at_end    = ({4'd0, byte_count_r} == frame_total);
    stat.crc_bad   = (crc_acc_r != crc_rx_r);
    stat.cmd_bad   = (head_cmd_r != want_cmd_r);
    stat.len_zero  = (frame_len_r == 8'd0);
    stat.out_last  = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reply_sof_r     <= 8'd0;
      crc_init_r      <= 16'hFFFF;
      timeout_ticks_r <= 24'd20000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REPLY_SOF:     reply_sof_r     <= cfg_wdata[7:0];
        CFG_CRC_INIT:      crc_init_r      <= cfg_wdata[15:0];
        CFG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r      <= 1'b0;
      byte_count_r <= 5'd0;
      want_cmd_r   <= 8'd0;
      frame_len_r  <= 8'd0;
      crc_acc_r    <= 16'hFFFF;
      crc_rx_r     <= 16'd0;
      head_sof_r   <= 8'd0;
      head_cmd_r   <= 8'd0;
      time_left_r  <= 24'd0;
      desync_r     <= 32'd0;
      type_r       <= REQ_ARM;
    end else begin
      unique case (cmd.op)
        DP_LOAD: begin
          type_r      <= in_req_type;
          item_cmd_r  <= in_expected_cmd;
          item_byte_r <= in_rx_byte;
        end
        DP_ARM: begin
          armed_r      <= 1'b1;
          byte_count_r <= 5'd0;
          want_cmd_r   <= item_cmd_r;
          frame_len_r  <= 8'd0;
          crc_acc_r    <= crc_init_r;
          crc_rx_r     <= 16'd0;
          head_sof_r   <= 8'd0;
          head_cmd_r   <= 8'd0;
          time_left_r  <= timeout_ticks_r;
        end
        DP_TICK: time_left_r <= time_left_r - 24'd1;
        DP_BYTE: begin
          byte_count_r <= byte_count_r + 5'd1;
          if (byte_count_r == 5'd0) begin
            head_sof_r <= item_byte_r;
          end else if (byte_count_r <= 5'd2) begin
            if (byte_count_r == 5'd1) begin
              head_cmd_r <= item_byte_r;
            end else begin
              frame_len_r <= item_byte_r;
            end
            crc_acc_r <= crc_next;
          end else if ({3'd0, pay_pos} < frame_len_r) begin
            crc_acc_r <= crc_next;
            if (pay_pos < 5'(PAY_LIMIT)) begin
              payload_r[pay_pos[3:0]] <= item_byte_r;
            end
          end else begin
            // trailing CRC, high byte first
            crc_rx_r <= {crc_rx_r[7:0], item_byte_r};
          end
        end
        DP_REJECT: begin
          armed_r  <= 1'b0;
          desync_r <= desync_r + 32'd1;
        end
        DP_EMPTY, DP_FIRST: armed_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_REJECT: begin
        status_r      <= cmd.code;
        data_byte_r   <= 8'd0;
        data_valid_r  <= 1'b0;
        byte_index_r  <= 4'd0;
        payload_len_r <= 4'd0;
        last_r        <= 1'b1;
        desync_out_r  <= desync_r + 32'd1;
      end
      DP_EMPTY: begin
        status_r      <= ST_OK;
        data_byte_r   <= 8'd0;
        data_valid_r  <= 1'b0;
        byte_index_r  <= 4'd0;
        payload_len_r <= 4'd0;
        last_r        <= 1'b1;
        desync_out_r  <= desync_r;
      end
      DP_FIRST: begin
        status_r      <= ST_OK;
        data_byte_r   <= payload_r[0];
        data_valid_r  <= 1'b1;
        byte_index_r  <= 4'd0;
        payload_len_r <= frame_len_r[3:0];
        last_r        <= (frame_len_r[3:0] == 4'd1);
        desync_out_r  <= desync_r;
      end
      DP_NEXT: begin
        data_byte_r  <= payload_r[next_index];
        byte_index_r <= next_index;
        last_r       <= ((next_index + 4'd1) == payload_len_r);
      end
      default: ;
    endcase
  end

  assign out_status       = status_r;
  assign out_data_byte    = data_byte_r;
  assign out_data_valid   = data_valid_r;
  assign out_byte_index   = byte_index_r;
  assign out_payload_len  = payload_len_r;
  assign out_last         = last_r;
  assign out_desync_count = desync_out_r;

  // the counter moves only on a rejection
  a_desync_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (desync_r != $past(desync_r))) |->
      ($past(cmd.op) == DP_REJECT && desync_r == $past(desync_r) + 32'd1))
    else $error("desync counter changed outside a rejection");

  // a payload byte always sits inside the reported length
  a_index_in_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && data_valid_r) |-> (byte_index_r < payload_len_r && status_r == ST_OK))
    else $error("payload index outside reply length");

endmodule

// File: rtl/crc_checked_reply_frame_receiver_core.sv
// Reply frame receiver: start byte, command, length, payload up to the limit, and a
// big-endian CRC16-CCITT over command, length and payload. An arm item sets the expected
// command and reloads the timeout; byte items build the frame, tick items count down.
// An item that does work is captured on its transfer, then updates the frame state and
// CRC (a whole byte per cycle), then runs the frame checks in the controller before the
// input is ready again. An item that is ignored (a byte or tick while disarmed, or an
// unknown type) is captured, then dropped. A completion then offers its results one
// per cycle from the output register while the sink is ready: a single status result on a
// rejection or an empty payload, or one result per payload byte. No item is taken while
// results are pending. Configuration writes are taken in any cycle; the CRC initial value
// and the timeout apply from the next arm item, the start byte from the next frame check.
module crc_checked_reply_frame_receiver_core
  import crcrx_pkg::*;
#(
  parameter int FRAME_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  crcrx_in_if.sink    in_ch,
  crcrx_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  localparam int PAY_LIMIT = ((FRAME_BYTES - 5) < PAY_DEPTH) ? (FRAME_BYTES - 5) : PAY_DEPTH;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;
  logic     out_valid;

  crcrx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  crcrx_dp #(
    .PAY_LIMIT (PAY_LIMIT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_req_type      (in_ch.req_type),
    .in_expected_cmd  (in_ch.expected_cmd),
    .in_rx_byte       (in_ch.rx_byte),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_status       (out_ch.status),
    .out_data_byte    (out_ch.data_byte),
    .out_data_valid   (out_ch.data_valid),
    .out_byte_index   (out_ch.byte_index),
    .out_payload_len  (out_ch.payload_len),
    .out_last         (out_ch.last),
    .out_desync_count (out_ch.desync_count)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

// File: test/crc_checked_reply_frame_receiver_core_test.sv
// Self-checking bench for the CRC-checked reply frame receiver: queued request items,
// a clocked driver and monitor, and a cycle-free predictor of every reply result.
// Depends on crcrx_pkg, the crcrx_in_if / crcrx_out_if interfaces and the core.
`timescale 1ns / 100ps

module crc_checked_reply_frame_receiver_core_test;
  import crcrx_pkg::*;

  localparam int FRAME_BYTES = 16;
  localparam int PAYLOAD_MAX = (FRAME_BYTES - 5 < PAY_DEPTH) ? FRAME_BYTES - 5 : PAY_DEPTH;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 6;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE = 12;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] cmd;
    logic [7:0] data;
    logic       drain;
  } rx_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic [3:0]  byte_index;
    logic [3:0]  payload_len;
    logic        last;
    logic [31:0] desync_count;
  } reply_result_t;

  typedef enum {SEQ_GOOD, SEQ_MAX_LEN, SEQ_BAD_SOF, SEQ_TOO_LONG, SEQ_BAD_CRC, SEQ_BAD_CMD,
                SEQ_CUT, SEQ_NOISE, SEQ_TIMEOUT} seq_kind_t;
  typedef enum {RDY_ALWAYS, RDY_COIN, RDY_ONE_IN_FOUR, RDY_MOSTLY} ready_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        src_valid = 1'b0;
  logic [1:0]  src_kind = REQ_TICK;
  logic [7:0]  src_cmd = 8'h00;
  logic [7:0]  src_byte = 8'h00;
  logic        sink_ready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_REPLY_SOF;
  logic [23:0] cfg_wdata = 24'h0;

  crcrx_in_if  in_ch ();
  crcrx_out_if out_ch ();

  assign in_ch.valid        = src_valid;
  assign in_ch.req_type     = src_kind;
  assign in_ch.expected_cmd = src_cmd;
  assign in_ch.rx_byte      = src_byte;
  assign out_ch.ready       = sink_ready;

  crc_checked_reply_frame_receiver_core #(.FRAME_BYTES(FRAME_BYTES)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copies, as last written
  logic [7:0]  sof_cfg = 8'h00;
  logic [15:0] crc_init_cfg = 16'hFFFF;
  logic [23:0] timeout_cfg = 24'd20000;

  // receiver state copy
  logic        arm_on = 1'b0;
  logic [4:0]  rx_count = 5'd0;
  logic [7:0]  cmd_want = 8'h00;
  logic [7:0]  len_seen = 8'h00;
  logic [15:0] crc_run = 16'hFFFF;
  logic [15:0] crc_got = 16'h0000;
  logic [7:0]  sof_seen = 8'h00;
  logic [7:0]  cmd_seen = 8'h00;
  logic [7:0]  pay_buf [PAY_DEPTH] = '{default: 8'h00};
  logic [23:0] ticks_left = 24'd0;
  logic [31:0] desync_total = 32'd0;

  rx_req_t       pending_reqs [$];
  reply_result_t results_due [$];
  int items_queued = 0;
  int items_taken = 0;
  int fails = 0;
  int hold_reqs = 0;

  function automatic logic [15:0] crc16_shift_in(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r = {r[14:0], 1'b0};
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  function automatic void push_result(input logic [2:0] st, input logic [7:0] db,
                                      input logic dv, input logic [3:0] bi,
                                      input logic [3:0] rl, input logic lst);
    results_due.push_back('{st, db, dv, bi, rl, lst, desync_total});
  endfunction

  function automatic void reject_reply(input logic [2:0] code);
    desync_total = desync_total + 32'd1;
    arm_on = 1'b0;
    push_result(code, 8'h00, 1'b0, 4'd0, 4'd0, 1'b1);
  endfunction

  task automatic predict_reply(input rx_req_t r);
    logic [4:0] idx;
    logic [4:0] slot;
    if (r.kind == REQ_ARM) begin
      arm_on = 1'b1;
      rx_count = 5'd0;
      cmd_want = r.cmd;
      len_seen = 8'h00;
      crc_run = crc_init_cfg;
      crc_got = 16'h0000;
      sof_seen = 8'h00;
      cmd_seen = 8'h00;
      ticks_left = timeout_cfg;
      if (ticks_left == 24'd0) reject_reply(ST_TIMEOUT);
      return;
    end
    if (!arm_on || r.kind == REQ_UNUSED) return;
    if (r.kind == REQ_TICK) begin
      ticks_left = ticks_left - 24'd1;
      if (ticks_left == 24'd0) reject_reply(ST_TIMEOUT);
      return;
    end
    idx = rx_count;
    if (idx == 5'd0) begin
      sof_seen = r.data;
    end else if (idx <= 5'd2) begin
      if (idx == 5'd1) cmd_seen = r.data;
      else len_seen = r.data;
      crc_run = crc16_shift_in(crc_run, r.data);
    end else begin
      slot = idx - 5'd3;
      if (slot < len_seen) begin
        crc_run = crc16_shift_in(crc_run, r.data);
        if (slot < PAYLOAD_MAX) pay_buf[slot[3:0]] = r.data;
      end else begin
        crc_got = {crc_got[7:0], r.data};
      end
    end
    rx_count = idx + 5'd1;
    if (rx_count < 5'd5) return;
    // start byte is checked before the length, from the fifth byte on
    if (sof_seen != sof_cfg) begin
      reject_reply(ST_BAD_START);
      return;
    end
    if (len_seen > PAYLOAD_MAX) begin
      reject_reply(ST_TOO_LONG);
      return;
    end
    if (int'(rx_count) < int'(len_seen) + 5) return;
    if (crc_run != crc_got) begin
      reject_reply(ST_CRC_BAD);
      return;
    end
    if (cmd_seen != cmd_want) begin
      reject_reply(ST_CMD_BAD);
      return;
    end
    arm_on = 1'b0;
    if (len_seen == 8'h00) begin
      push_result(ST_OK, 8'h00, 1'b0, 4'd0, 4'd0, 1'b1);
    end else begin
      for (int k = 0; k < int'(len_seen); k++)
        push_result(ST_OK, pay_buf[k], 1'b1, k[3:0], len_seen[3:0], k + 1 == int'(len_seen));
    end
  endtask

  // driver: bursts of transfers with random gaps
  rx_req_t cur_req;
  int gap_left = 0;
  int burst_left = 1;

  always @(posedge clk) begin
    if (!rst_n) begin
      src_valid <= 1'b0;
    end else begin
      if (src_valid && in_ch.ready) begin
        predict_reply(cur_req);
        items_taken++;
      end
      if (!src_valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          src_valid <= 1'b0;
        end else if (pending_reqs.size() != 0 && pending_reqs[0].drain) begin
          // hold back until the block has delivered everything owed
          src_valid <= 1'b0;
          if (results_due.size() == 0) void'(pending_reqs.pop_front());
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          src_valid <= 1'b1;
          src_kind <= cur_req.kind;
          src_cmd <= cur_req.cmd;
          src_byte <= cur_req.data;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure: a changing pattern, plus an occasional long hold-off
  ready_mode_t rdy_mode = RDY_ALWAYS;
  int mode_left = 0;
  int hold_left = 0;
  int hold_served = 0;
  int rdy_cycle = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      sink_ready <= 1'b0;
    end else begin
      rdy_cycle++;
      if (hold_served != hold_reqs) begin
        hold_served = hold_reqs;
        hold_left = LONG_HOLD;
        sink_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        sink_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rdy_mode = ready_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end else begin
          mode_left--;
        end
        case (rdy_mode)
          RDY_ALWAYS:      sink_ready <= 1'b1;
          RDY_COIN:        sink_ready <= $urandom_range(0, 1);
          RDY_ONE_IN_FOUR: sink_ready <= (rdy_cycle % 4 == 0);
          default:         sink_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] expd,
                                      input logic [31:0] got);
    if (expd !== got) begin
      $error("%s: expected %0h, got %0h", name, expd, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    reply_result_t due;
    if (rst_n && out_ch.valid && sink_ready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: status %0d data %0h", out_ch.status, out_ch.data_byte);
        fails++;
      end else begin
        due = results_due.pop_front();
        check_field("status", due.status, out_ch.status);
        check_field("data_byte", due.data_byte, out_ch.data_byte);
        check_field("data_valid", due.data_valid, out_ch.data_valid);
        check_field("byte_index", due.byte_index, out_ch.byte_index);
        check_field("payload_len", due.payload_len, out_ch.payload_len);
        check_field("last", due.last, out_ch.last);
        check_field("desync_count", due.desync_count, out_ch.desync_count);
      end
    end
  end

  task automatic push_item(input logic [1:0] kind, input logic [7:0] cmd, input logic [7:0] data);
    pending_reqs.push_back('{kind, cmd, data, 1'b0});
    items_queued++;
  endtask

  // arm, then the reply bytes (first 'keep' of them), optionally with ticks in between
  task automatic push_reply(input logic [7:0] want, input logic [7:0] sof, input logic [7:0] cmd,
                            input logic [7:0] len, input int keep, input logic [15:0] crc_flip,
                            input bit with_ticks);
    logic [7:0]  frame [$];
    logic [7:0]  b;
    logic [15:0] crc;
    int          n;
    frame.push_back(sof);
    frame.push_back(cmd);
    frame.push_back(len);
    crc = crc16_shift_in(crc16_shift_in(crc_init_cfg, cmd), len);
    n = (len > 8'd16) ? 16 : int'(len);
    for (int k = 0; k < n; k++) begin
      b = $urandom_range(0, 255);
      frame.push_back(b);
      crc = crc16_shift_in(crc, b);
    end
    crc = crc ^ crc_flip;
    frame.push_back(crc[15:8]);
    frame.push_back(crc[7:0]);
    push_item(REQ_ARM, want, $urandom_range(0, 255));
    for (int k = 0; k < frame.size() && k < keep; k++) begin
      if (with_ticks && $urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 2)) push_item(REQ_TICK, $urandom_range(0, 255),
                                                $urandom_range(0, 255));
      push_item(REQ_BYTE, $urandom_range(0, 255), frame[k]);
    end
  endtask

  task automatic add_random_sequence(input int seq_no);
    seq_kind_t   kind;
    logic [7:0]  want;
    logic [7:0]  sof;
    logic [7:0]  cmd;
    logic [7:0]  len;
    logic [15:0] flip;
    int          keep;
    int          roll;
    int          ticks;
    case (seq_no)
      0: kind = SEQ_MAX_LEN;
      1: kind = SEQ_TOO_LONG;
      2: kind = SEQ_BAD_CRC;
      3: kind = SEQ_BAD_CMD;
      default: begin
        roll = $urandom_range(0, 19);
        if (roll < 10) kind = SEQ_GOOD;
        else if (roll == 10) kind = SEQ_BAD_SOF;
        else if (roll == 11) kind = SEQ_TOO_LONG;
        else if (roll == 12) kind = SEQ_BAD_CRC;
        else if (roll == 13) kind = SEQ_BAD_CMD;
        else if (roll < 16) kind = SEQ_CUT;
        else if (roll < 18) kind = SEQ_NOISE;
        else if (roll == 18) kind = SEQ_TIMEOUT;
        else kind = SEQ_MAX_LEN;
      end
    endcase
    want = $urandom_range(0, 255);
    cmd = want;
    sof = sof_cfg;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, PAYLOAD_MAX) : $urandom_range(0, 3);
    flip = 16'h0000;
    keep = 99;
    case (kind)
      SEQ_MAX_LEN: len = PAYLOAD_MAX;
      SEQ_BAD_SOF: sof = sof ^ 8'($urandom_range(1, 255));
      SEQ_TOO_LONG: begin
        len = $urandom_range(PAYLOAD_MAX + 1, 255);
        keep = 5;
      end
      SEQ_BAD_CRC: flip = $urandom_range(1, 65535);
      SEQ_BAD_CMD: cmd = want ^ 8'($urandom_range(1, 255));
      SEQ_CUT: keep = $urandom_range(1, int'(len) + 4);
      default: ;
    endcase
    if (kind == SEQ_NOISE) begin
      repeat ($urandom_range(1, 4))
        push_item($urandom_range(0, 3), $urandom_range(0, 255), $urandom_range(0, 255));
    end else if (kind == SEQ_TIMEOUT) begin
      ticks = (timeout_cfg > 24'd48) ? 48 : int'(timeout_cfg);
      push_item(REQ_ARM, want, $urandom_range(0, 255));
      repeat (ticks) push_item(REQ_TICK, $urandom_range(0, 255), $urandom_range(0, 255));
    end else begin
      push_reply(want, sof, cmd, len, keep, flip, 1'b1);
      // a broken-off frame is followed by a fresh arm and a clean reply
      if (kind == SEQ_CUT) push_reply(want, sof_cfg, want, len, 99, 16'h0000, 1'b1);
    end
  endtask

  // leaves the block disarmed: a wrong start byte always ends the frame at byte five
  task automatic push_flush();
    push_item(REQ_ARM, $urandom_range(0, 255), $urandom_range(0, 255));
    push_item(REQ_BYTE, $urandom_range(0, 255), ~sof_cfg);
    repeat (4) push_item(REQ_BYTE, $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  task automatic push_drain();
    pending_reqs.push_back('{REQ_TICK, 8'h00, 8'h00, 1'b1});
  endtask

  task automatic wait_for_idle();
    while (items_taken != items_queued || results_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [23:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_REPLY_SOF:     sof_cfg = data[7:0];
      CFG_CRC_INIT:      crc_init_cfg = data[15:0];
      CFG_TIMEOUT_TICKS: timeout_cfg = data;
      default: ;
    endcase
  endtask

  task automatic set_registers(input logic [7:0] sof, input logic [15:0] crc_init,
                               input logic [23:0] tmo);
    logic [23:0] junk;
    junk = $urandom;
    cfg_write(CFG_REPLY_SOF, {junk[23:8], sof});
    cfg_write(CFG_CRC_INIT, {junk[7:0], crc_init});
    cfg_write(CFG_TIMEOUT_TICKS, tmo);
  endtask

  initial begin
    int  start;
    int  seq_no;
    bit  drained;
    seq_no = 0;
    drained = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values first
    repeat (4) begin
      add_random_sequence(seq_no);
      seq_no++;
    end
    push_flush();
    wait_for_idle();

    // directed: idle items, empty and one-byte replies, timeout, re-arm, bad start
    set_registers(8'hFF, 16'h0000, 24'd2);
    push_item(REQ_BYTE, 8'hFF, 8'h00);
    push_item(REQ_TICK, 8'h00, 8'hFF);
    push_item(REQ_UNUSED, 8'h00, 8'hFF);
    push_reply(8'h00, 8'hFF, 8'h00, 8'd0, 99, 16'h0000, 1'b0);
    push_reply(8'hFF, 8'hFF, 8'hFF, 8'd1, 99, 16'h0000, 1'b0);
    push_item(REQ_ARM, 8'h3C, 8'h00);
    push_item(REQ_UNUSED, 8'hA5, 8'h5A);
    push_item(REQ_TICK, 8'h00, 8'h00);
    push_item(REQ_TICK, 8'hFF, 8'hFF);
    push_item(REQ_ARM, 8'h11, 8'h00);
    push_item(REQ_BYTE, 8'h00, 8'hFF);
    push_reply(8'h22, 8'h00, 8'h22, 8'd0, 5, 16'h0000, 1'b0);
    wait_for_idle();

    // zero timeout rejects on the arm itself; the spare index must be ignored
    cfg_write(CFG_TIMEOUT_TICKS, 24'h000000);
    cfg_write(CFG_UNUSED, $urandom);
    push_item(REQ_ARM, 8'h5A, 8'hA5);
    push_item(REQ_BYTE, 8'h00, 8'h00);
    push_item(REQ_TICK, 8'h00, 8'h00);
    wait_for_idle();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: set_registers(8'h00, 16'hFFFF, 24'hFFFFFF);
        1: set_registers($urandom_range(0, 255), $urandom_range(0, 65535), 24'd1);
        3: set_registers(8'hFF, 16'h0000, $urandom_range(6, 40));
        default: set_registers($urandom_range(0, 255), $urandom_range(0, 65535),
                               $urandom_range(6, 40));
      endcase
      if (p == 2) hold_reqs++;
      start = items_queued;
      while (items_queued - start < PHASE_ITEMS) begin
        add_random_sequence(seq_no);
        seq_no++;
        if (p == 3 && !drained && items_queued - start >= PHASE_ITEMS / 2) begin
          push_drain();
          drained = 1'b1;
        end
      end
      push_flush();
      wait_for_idle();
    end

    if (fails == 0) begin
      $display("[crc_checked_reply_frame_receiver_core] OK");
    end else begin
      $display("[crc_checked_reply_frame_receiver_core] ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("[crc_checked_reply_frame_receiver_core] ERROR");
    $finish;
  end

endmodule
